@@ hw/rtl/sha256_pkg.sv @@
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } ctrl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load_byte;   // shift request byte into the block window
    logic pad_byte;    // shift padding or length byte into the block window
    logic pad_mark;    // padding byte is the 0x80 marker
    logic pad_len;     // this block carries the length in its last 8 bytes
    logic start_blk;   // load working words from chaining value
    logic do_round;    // one compression round
    logic fold;        // add working words into chaining value
    logic reset_msg;   // reload initial hash, clear counters
    logic shift_out;   // rotate chaining value for output
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       round_last;
  } sha_status_t;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ hw/rtl/sha256_datapath.sv @@
module sha256_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sha256_pkg::sha_cmd_t   cmd_i,
  input  logic [7:0]             byte_i,
  output sha256_pkg::sha_status_t status_o,
  output logic [31:0]            digest_o
);
  import sha256_pkg::*;

  logic [31:0] win_q [16];
  logic [31:0] w_q [8];
  logic [31:0] h_q [8];
  logic [5:0]  fill_q, round_q;
  logic [63:0] bits_q;

  logic [7:0]  pad_val, wr_byte;
  logic [31:0] wt, m0, m1, s0, s1, ch, maj, t1, t2;
  logic [2:0]  len_idx;

  // padding: 0x80 first, zeros, then big-endian length in the last 8 bytes
  always_comb begin
    len_idx = fill_q[2:0];
    if (cmd_i.pad_mark)                          pad_val = PadByte;
    else if (cmd_i.pad_len && fill_q >= 6'd56)   pad_val = bits_q[{~len_idx, 3'b000} +: 8];
    else                                         pad_val = 8'h00;
    wr_byte = cmd_i.load_byte ? byte_i : pad_val;
  end

  // window slot 0 holds round t schedule word after shifting
  always_comb begin
    m0 = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
    m1 = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
    wt = win_q[0];
    s1 = rotr(w_q[4], 6) ^ rotr(w_q[4], 11) ^ rotr(w_q[4], 25);
    ch = (w_q[4] & w_q[5]) ^ (~w_q[4] & w_q[6]);
    t1 = w_q[7] + s1 + ch + RoundK[round_q] + wt;
    s0 = rotr(w_q[0], 2) ^ rotr(w_q[0], 13) ^ rotr(w_q[0], 22);
    maj = (w_q[0] & w_q[1]) ^ (w_q[0] & w_q[2]) ^ (w_q[1] & w_q[2]);
    t2 = s0 + maj;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      round_q <= '0;
      bits_q  <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
    end else begin
      if (cmd_i.reset_msg) begin
        fill_q <= '0;
        bits_q <= '0;
        for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
      end else begin
        if (cmd_i.load_byte) begin
          fill_q <= fill_q + 6'd1;
          bits_q <= bits_q + 64'd8;
        end else if (cmd_i.pad_byte) begin
          fill_q <= fill_q + 6'd1;
        end
        if (cmd_i.fold) begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + w_q[i];
        end else if (cmd_i.shift_out) begin
          for (int i = 0; i < 7; i++) h_q[i] <= h_q[i + 1];
          h_q[7] <= h_q[0];
        end
      end
      if (cmd_i.start_blk) round_q <= '0;
      else if (cmd_i.do_round) round_q <= round_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte || cmd_i.pad_byte) begin
      // bytes enter big-endian, the first byte ends up in the top of slot 0
      for (int i = 0; i < 15; i++) win_q[i] <= {win_q[i][23:0], win_q[i + 1][31:24]};
      win_q[15] <= {win_q[15][23:0], wr_byte};
    end else if (cmd_i.do_round) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
      win_q[15] <= win_q[0] + m0 + win_q[9] + m1;
    end
    if (cmd_i.start_blk) begin
      for (int i = 0; i < 8; i++) w_q[i] <= h_q[i];
    end else if (cmd_i.do_round) begin
      w_q[7] <= w_q[6];
      w_q[6] <= w_q[5];
      w_q[5] <= w_q[4];
      w_q[4] <= w_q[3] + t1;
      w_q[3] <= w_q[2];
      w_q[2] <= w_q[1];
      w_q[1] <= w_q[0];
      w_q[0] <= t1 + t2;
    end
  end

  assign status_o.fill       = fill_q;
  assign status_o.round_last = (round_q == 6'd63);
  assign digest_o            = h_q[0];

endmodule

@@ hw/rtl/sha256_ctrl.sv @@
module sha256_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    byte_present_i,
  input  logic                    end_of_message_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [2:0]              word_number_o,
  output logic                    final_word_o,
  input  sha256_pkg::sha_status_t status_i,
  output sha256_pkg::sha_cmd_t    cmd_o
);
  import sha256_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        closing_q, closing_d;  // block belongs to the final padding
  logic        pad_started_q, pad_started_d; // 0x80 already written
  logic        len_blk_q, len_blk_d;  // current block carries the length
  logic [2:0]  word_q, word_d;
  logic        acc;
  logic        blk_full;

  assign acc      = in_valid_i && (state_q == ST_IDLE);
  assign blk_full = (status_i.fill == 6'd63);

  always_comb begin
    state_d       = state_q;
    closing_d     = closing_q;
    pad_started_d = pad_started_q;
    len_blk_d     = len_blk_q;
    word_d        = word_q;
    case (state_q)
      ST_IDLE: if (acc) begin
        closing_d     = end_of_message_i;
        pad_started_d = 1'b0;
        len_blk_d     = 1'b0;
        if (byte_present_i && blk_full) state_d = ST_ROUND;
        else if (end_of_message_i)      state_d = ST_PAD;
      end
      ST_PAD: begin
        pad_started_d = 1'b1;
        // marker early enough leaves room for the length in this block
        if (!pad_started_q && status_i.fill < 6'd56) len_blk_d = 1'b1;
        if (blk_full) state_d = ST_ROUND;
      end
      ST_ROUND: if (status_i.round_last) state_d = ST_FOLD;
      ST_FOLD: begin
        if (!closing_q) begin
          state_d = ST_IDLE;
        end else if (len_blk_q) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_PAD;
          if (pad_started_q) len_blk_d = 1'b1;
        end
      end
      ST_EMIT: if (out_ready_i) begin
        word_d = word_q + 3'd1;
        if (word_q == 3'd7) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_EMIT);
    case (state_q)
      ST_IDLE: begin
        cmd_o.load_byte = acc && byte_present_i;
        cmd_o.start_blk = acc && byte_present_i && blk_full;
      end
      ST_PAD: begin
        cmd_o.pad_byte  = 1'b1;
        cmd_o.pad_mark  = !pad_started_q;
        cmd_o.pad_len   = len_blk_q;
        cmd_o.start_blk = blk_full;
      end
      ST_ROUND: cmd_o.do_round = 1'b1;
      ST_FOLD:  cmd_o.fold = 1'b1;
      ST_EMIT: if (out_ready_i) begin
        cmd_o.shift_out = 1'b1;
        if (word_q == 3'd7) cmd_o.reset_msg = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      closing_q     <= 1'b0;
      pad_started_q <= 1'b0;
      len_blk_q     <= 1'b0;
      word_q        <= '0;
    end else begin
      state_q       <= state_d;
      closing_q     <= closing_d;
      pad_started_q <= pad_started_d;
      len_blk_q     <= len_blk_d;
      word_q        <= word_d;
    end
  end

  assign word_number_o = word_q;
  assign final_word_o  = (word_q == 3'd7);

endmodule

@@ hw/rtl/sha256_message_hasher.sv @@
// sha-256 hasher, one request byte per input item
// byte item: a load, plus 64 rounds and a fold when it completes a 64-byte block
// end item: padding bytes written one per cycle up to the block end, then per padded block
// 64 rounds and a fold, then 8 output words, one per cycle while the receiver is ready
// throughput set by the single shared round unit, one round per cycle
// asynchronous active-low reset loads the initial hash values and clears counters
module sha256_message_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_number_o,
  output logic        final_word_o
);
  import sha256_pkg::*;

  sha_cmd_t    cmd;
  sha_status_t status;

  sha256_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .byte_present_i, .end_of_message_i,
    .out_ready_i, .out_valid_o, .word_number_o, .final_word_o,
    .status_i(status), .cmd_o(cmd)
  );

  sha256_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .byte_i(data_byte_i),
    .status_o(status), .digest_o(digest_word_o)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        byte_present_i;
  logic        end_of_message_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] digest_word_o;
  logic [2:0]  word_number_o;
  logic        final_word_o;

  sha256_message_hasher dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .byte_present_i   (byte_present_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .digest_word_o    (digest_word_o),
    .word_number_o    (word_number_o),
    .final_word_o     (final_word_o)
  );

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       eom;
  } byte_req_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  num;
    logic        last;
  } digest_out_t;

  byte_req_t   pending_reqs[$];
  digest_out_t expected_words[$];

  // predictor state
  logic [31:0] hash_state[8];
  logic [7:0]  blk_buf[64];
  int unsigned blk_fill;
  logic [63:0] bit_len;

  int  error_count;
  bit  stim_done;
  bit  hold_off;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_blk();
    logic [31:0] sched[64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      sched[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    for (int i = 16; i < 64; i++)
      sched[i] = sched[i-16]
               + (ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3))
               + sched[i-7]
               + (ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10));
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + sha256_pkg::RoundK[i] + sched[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic restart_msg();
    for (int i = 0; i < 8; i++) hash_state[i] = sha256_pkg::InitH[i];
    blk_fill = 0;
    bit_len  = '0;
  endtask

  task automatic predict_digest(byte_req_t r);
    digest_out_t d;
    if (r.present) begin
      blk_buf[blk_fill] = r.data;
      bit_len += 64'd8;
      blk_fill = (blk_fill + 1) % 64;
      if (blk_fill == 0) compress_blk();
    end
    if (!r.eom) return;
    blk_buf[blk_fill] = sha256_pkg::PadByte;
    blk_fill++;
    if (blk_fill > 56) begin
      while (blk_fill < 64) begin
        blk_buf[blk_fill] = 8'h00;
        blk_fill++;
      end
      compress_blk();
      blk_fill = 0;
    end
    while (blk_fill < 56) begin
      blk_buf[blk_fill] = 8'h00;
      blk_fill++;
    end
    for (int i = 0; i < 8; i++) blk_buf[56+i] = bit_len[63-8*i -: 8];
    compress_blk();
    for (int i = 0; i < 8; i++) begin
      d.word = hash_state[i];
      d.num  = 3'(i);
      d.last = (i == 7);
      expected_words.push_back(d);
    end
    restart_msg();
  endtask

  task automatic add_req(logic [7:0] data, logic present, logic eom);
    byte_req_t r;
    r.data = data; r.present = present; r.eom = eom;
    pending_reqs.push_back(r);
  endtask

  task automatic add_message(int len, bit eom_on_last);
    for (int i = 0; i < len; i++)
      add_req(8'($urandom), 1'b1, eom_on_last && (i == len - 1));
    if (!eom_on_last || len == 0) add_req(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    int n;
    error_count = 0;
    stim_done   = 1'b0;
    restart_msg();
    // directed: empty message, extremes, ignored bytes, padding boundaries
    add_req(8'hff, 1'b0, 1'b1);
    add_req(8'h00, 1'b1, 1'b1);
    add_req(8'hff, 1'b1, 1'b1);
    add_req(8'h5a, 1'b0, 1'b0);
    add_req(8'h61, 1'b1, 1'b0);
    add_req(8'h62, 1'b1, 1'b0);
    add_req(8'hc3, 1'b0, 1'b0);
    add_req(8'h63, 1'b1, 1'b0);
    add_req(8'h00, 1'b0, 1'b1);
    add_req(8'haa, 1'b1, 1'b0);
    add_req(8'h55, 1'b1, 1'b1);
    add_message(55, 1'b1);
    add_message(56, 1'b0);
    add_message(64, 1'b1);
    // random messages, mostly short, a few across block boundaries
    while (pending_reqs.size() < 290) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 80) : $urandom_range(0, 12);
      for (int i = 0; i < n; i++)
        if ($urandom_range(0, 9) == 0) add_req(8'($urandom), 1'b0, 1'b0);
        else add_req(8'($urandom), 1'b1, 1'b0);
      add_req(8'($urandom), 1'($urandom), 1'b1);
    end
    stim_done = 1'b1;
  end

  // driver: bursts with random gaps
  int burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i       <= 1'b0;
      data_byte_i      <= '0;
      byte_present_i   <= 1'b0;
      end_of_message_i <= 1'b0;
      burst_left       <= 0;
      gap_left         <= 0;
    end else begin
      if (in_valid_i && in_ready_o)
        predict_digest({data_byte_i, byte_present_i, end_of_message_i});
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0 || pending_reqs.size() == 0) begin
          in_valid_i <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          byte_req_t r;
          r = pending_reqs.pop_front();
          in_valid_i       <= 1'b1;
          data_byte_i      <= r.data;
          byte_present_i   <= r.present;
          end_of_message_i <= r.eom;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver stall pattern plus one long hold-off
  int rx_phase;
  int hold_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_phase    <= 0;
      hold_cnt    <= 0;
      hold_off    <= 1'b0;
    end else begin
      rx_phase <= rx_phase + 1;
      if (!hold_off && hold_cnt == 0 && rx_phase == 400) begin
        hold_off <= 1'b1;
        hold_cnt <= 2000;
        out_ready_i <= 1'b0;
      end else if (hold_off) begin
        hold_cnt <= hold_cnt - 1;
        if (hold_cnt == 1) hold_off <= 1'b0;
        out_ready_i <= 1'b0;
      end else if ((rx_phase / 500) % 2 == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $display("%0t: digest word with none expected: word %h num %0d last %0b",
                 $time, digest_word_o, word_number_o, final_word_o);
        error_count++;
      end else begin
        digest_out_t e;
        e = expected_words.pop_front();
        if (e.word !== digest_word_o) begin
          $display("%0t: digest_word expected %h actual %h", $time, e.word, digest_word_o);
          error_count++;
        end
        if (e.num !== word_number_o) begin
          $display("%0t: word_number expected %0d actual %0d", $time, e.num, word_number_o);
          error_count++;
        end
        if (e.last !== final_word_o) begin
          $display("%0t: final_word expected %0b actual %0b", $time, e.last, final_word_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (pending_reqs.size() == 0 && !in_valid_i);
    wait (expected_words.size() == 0);
    repeat (300) @(posedge clk_i);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: errors");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_datapath.sv
hw/rtl/sha256_ctrl.sv
hw/rtl/sha256_message_hasher.sv
tb/testbench.sv
